// ----- sv/dmlc_pkg.sv -----
// Shared types and codes for the door motor learning controller.
package dmlc_pkg;

   localparam int REG_BITS = 20;

   localparam logic [3:0] OP_TICK        = 4'd0;
   localparam logic [3:0] OP_RF          = 4'd1;
   localparam logic [3:0] OP_OPEN        = 4'd2;
   localparam logic [3:0] OP_CLOSE       = 4'd3;
   localparam logic [3:0] OP_STOP        = 4'd4;
   localparam logic [3:0] OP_LOCK        = 4'd5;
   localparam logic [3:0] OP_UNLOCK      = 4'd6;
   localparam logic [3:0] OP_LOCK_TOGGLE = 4'd7;
   localparam logic [3:0] OP_LEARN_TRAVEL = 4'd8;
   localparam logic [3:0] OP_LEARN_RF    = 4'd9;
   localparam logic [3:0] OP_WIFI        = 4'd10;

   localparam logic [1:0] RELAY_OFF   = 2'd0;
   localparam logic [1:0] RELAY_OPEN  = 2'd1;
   localparam logic [1:0] RELAY_CLOSE = 2'd2;

   localparam logic [1:0] BEEP_NONE  = 2'd0;
   localparam logic [1:0] BEEP_SHORT = 2'd1;
   localparam logic [1:0] BEEP_LONG  = 2'd2;

   localparam logic [4:0] ST_NONE         = 5'd0;
   localparam logic [4:0] ST_STOP         = 5'd1;
   localparam logic [4:0] ST_OPEN         = 5'd2;
   localparam logic [4:0] ST_CLOSE        = 5'd3;
   localparam logic [4:0] ST_LOCKED_ERR   = 5'd4;
   localparam logic [4:0] ST_LOCKED       = 5'd5;
   localparam logic [4:0] ST_UNLOCKED     = 5'd6;
   localparam logic [4:0] ST_CAL_ON       = 5'd7;
   localparam logic [4:0] ST_CAL_DONE     = 5'd8;
   localparam logic [4:0] ST_CAL_SHORT    = 5'd9;
   localparam logic [4:0] ST_CAL_CANCEL   = 5'd10;
   localparam logic [4:0] ST_RF_WAIT_OPEN = 5'd11;
   localparam logic [4:0] ST_RF_DONE      = 5'd15;
   localparam logic [4:0] ST_RF_CANCEL    = 5'd16;
   localparam logic [4:0] ST_TIMEOUT      = 5'd17;

   localparam logic [1:0] REG_DEFAULT_TRAVEL = 2'd0;
   localparam logic [1:0] REG_MIN_LEARN      = 2'd1;
   localparam logic [1:0] REG_LEARN_TIMEOUT  = 2'd2;
   localparam logic [1:0] REG_RF_TIMEOUT     = 2'd3;

   localparam logic [REG_BITS-1:0] DEFAULT_TRAVEL_RESET = 20'd30000;
   localparam logic [REG_BITS-1:0] MIN_LEARN_RESET      = 20'd1000;
   localparam logic [REG_BITS-1:0] LEARN_TIMEOUT_RESET  = 20'd180000;
   localparam logic [REG_BITS-1:0] RF_TIMEOUT_RESET     = 20'd60000;

   typedef struct packed {
      logic [REG_BITS-1:0] default_travel_ms;
      logic [REG_BITS-1:0] min_learn_ms;
      logic [REG_BITS-1:0] learn_timeout_ms;
      logic [REG_BITS-1:0] rf_key_timeout_ms;
   } cfg_type;

   // Members run from the highest bit down, so relay_drive lands in bits [1:0].
   typedef struct packed {
      logic                locked;
      logic [REG_BITS-1:0] travel_time_ms;
      logic                save_travel;
      logic                save_codes;
      logic                wifi_config_start;
      logic [2:0]          timeout_mask;
      logic [1:0]          beep;
      logic [4:0]          status;
      logic [1:0]          relay_drive;
   } result_type;

endpackage

// ----- sv/dmlc_engine.sv -----
// Controller state and the combinational update for one transaction.
module dmlc_engine #(
   parameter int CODE_BITS = 24,
   parameter int TIME_BITS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [3:0]             op,
   input  logic [CODE_BITS-1:0]   code,
   input  dmlc_pkg::cfg_type      cfg,
   input  logic                   default_we,
   input  logic [dmlc_pkg::REG_BITS-1:0] default_value,
   output dmlc_pkg::result_type   result
);
   import dmlc_pkg::*;

   localparam logic [2:0] STEP_IDLE      = 3'd0;
   localparam logic [2:0] STEP_WAIT_OPEN = 3'd1;
   localparam logic [2:0] STEP_WAIT_LOCK = 3'd4;

   function automatic logic [TIME_BITS-1:0] period(input logic [TIME_BITS-1:0] v);
      return (v == '0) ? TIME_BITS'(1) : v;
   endfunction

   function automatic logic [TIME_BITS-1:0] to_time(input logic [REG_BITS-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      return w[TIME_BITS-1:0];
   endfunction

   logic                 lock_ff, lock_in;
   logic [1:0]           relay_ff, relay_in;
   logic [TIME_BITS-1:0] travel_ff, travel_in;
   logic [TIME_BITS-1:0] travel_rem_ff, travel_rem_in;
   logic [TIME_BITS-1:0] timeout_rem_ff, timeout_rem_in;
   logic                 tlearn_ff, tlearn_in;
   logic                 measuring_ff, measuring_in;
   logic [TIME_BITS-1:0] measured_ff, measured_in;
   logic                 wifi_ff, wifi_in;
   logic [2:0]           learn_step_ff, learn_step_in;
   logic                 learned_ff, learned_in;
   logic [CODE_BITS-1:0] saved_ff [4];
   logic [CODE_BITS-1:0] saved_in [4];
   logic [CODE_BITS-1:0] pending_ff [3];
   logic [CODE_BITS-1:0] pending_in [3];

   logic                 act_oc, act_stop, act_lock, lock_val;
   logic [1:0]           drive;
   logic [1:0]           pidx;
   logic [31:0]          travel_wide;
   logic [4:0]           status;
   logic [1:0]           beep;
   logic [2:0]           mask;
   logic                 wifi_start, save_codes, save_travel;

   assign pidx        = learn_step_ff[1:0] - 2'd1;
   assign travel_wide = 32'(travel_in);

   always_comb begin
      lock_in        = lock_ff;
      relay_in       = relay_ff;
      travel_in      = travel_ff;
      travel_rem_in  = travel_rem_ff;
      timeout_rem_in = timeout_rem_ff;
      tlearn_in      = tlearn_ff;
      measuring_in   = measuring_ff;
      measured_in    = measured_ff;
      wifi_in        = wifi_ff;
      learn_step_in  = learn_step_ff;
      learned_in     = learned_ff;
      saved_in       = saved_ff;
      pending_in     = pending_ff;
      status         = ST_NONE;
      beep           = BEEP_NONE;
      mask           = '0;
      wifi_start     = 1'b0;
      save_codes     = 1'b0;
      save_travel    = 1'b0;
      act_oc         = 1'b0;
      act_stop       = 1'b0;
      act_lock       = 1'b0;
      lock_val       = 1'b0;
      drive          = RELAY_OPEN;

      unique case (op)
         OP_TICK: begin
            if (measuring_ff && measured_ff != '1) begin
               measured_in = measured_ff + TIME_BITS'(1);
            end
            if (travel_rem_ff != '0) begin
               travel_rem_in = travel_rem_ff - TIME_BITS'(1);
               if (travel_rem_ff == TIME_BITS'(1)) begin
                  relay_in = RELAY_OFF;
                  status   = ST_STOP;
               end
            end
            if (timeout_rem_ff != '0) begin
               timeout_rem_in = timeout_rem_ff - TIME_BITS'(1);
               if (timeout_rem_ff == TIME_BITS'(1)) begin
                  if (wifi_ff) begin
                     mask[0] = 1'b1;
                     wifi_in = 1'b0;
                  end
                  if (learn_step_ff != STEP_IDLE) begin
                     mask[1]       = 1'b1;
                     learn_step_in = STEP_IDLE;
                  end
                  if (tlearn_ff) begin
                     mask[2]      = 1'b1;
                     tlearn_in    = 1'b0;
                     measuring_in = 1'b0;
                     measured_in  = '0;
                  end
                  relay_in = RELAY_OFF;
                  beep     = BEEP_SHORT;
                  status   = ST_TIMEOUT;
               end
            end
         end
         OP_RF: begin
            if (learn_step_ff != STEP_IDLE) begin
               beep = BEEP_SHORT;
               if (learn_step_ff != STEP_WAIT_LOCK) begin
                  pending_in[pidx] = code;
                  learn_step_in    = learn_step_ff + 3'd1;
                  status           = ST_RF_WAIT_OPEN + 5'(learn_step_ff);
                  timeout_rem_in   = period(to_time(cfg.rf_key_timeout_ms));
               end else begin
                  saved_in[0]    = pending_ff[0];
                  saved_in[1]    = pending_ff[1];
                  saved_in[2]    = pending_ff[2];
                  saved_in[3]    = code;
                  save_codes     = 1'b1;
                  learn_step_in  = STEP_IDLE;
                  timeout_rem_in = '0;
                  status         = ST_RF_DONE;
                  beep           = BEEP_LONG;
               end
            end else begin
               priority if (code == saved_ff[0]) begin
                  act_oc = 1'b1;
                  drive  = RELAY_OPEN;
               end else if (code == saved_ff[1]) begin
                  act_stop = 1'b1;
               end else if (code == saved_ff[2]) begin
                  act_oc = 1'b1;
                  drive  = RELAY_CLOSE;
               end else if (code == saved_ff[3]) begin
                  act_lock = 1'b1;
                  lock_val = !lock_ff;
               end
            end
         end
         OP_OPEN: begin
            act_oc = 1'b1;
            drive  = RELAY_OPEN;
         end
         OP_CLOSE: begin
            act_oc = 1'b1;
            drive  = RELAY_CLOSE;
         end
         OP_STOP: act_stop = 1'b1;
         OP_LOCK: begin
            act_lock = 1'b1;
            lock_val = 1'b1;
         end
         OP_UNLOCK: begin
            act_lock = 1'b1;
            lock_val = 1'b0;
         end
         OP_LOCK_TOGGLE: begin
            act_lock = 1'b1;
            lock_val = !lock_ff;
         end
         OP_LEARN_TRAVEL: begin
            if (lock_ff) begin
               status = ST_LOCKED_ERR;
               beep   = BEEP_SHORT;
            end else begin
               tlearn_in      = 1'b1;
               measuring_in   = 1'b0;
               measured_in    = '0;
               relay_in       = RELAY_OFF;
               timeout_rem_in = period(to_time(cfg.learn_timeout_ms));
               status         = ST_CAL_ON;
               beep           = BEEP_LONG;
            end
         end
         OP_LEARN_RF: begin
            if (lock_ff) begin
               status = ST_LOCKED_ERR;
            end else begin
               learn_step_in  = STEP_WAIT_OPEN;
               relay_in       = RELAY_OFF;
               timeout_rem_in = period(to_time(cfg.rf_key_timeout_ms));
               status         = ST_RF_WAIT_OPEN;
               beep           = BEEP_LONG;
            end
         end
         OP_WIFI: begin
            wifi_in        = 1'b1;
            relay_in       = RELAY_OFF;
            timeout_rem_in = period(to_time(cfg.learn_timeout_ms));
            wifi_start     = 1'b1;
            beep           = BEEP_LONG;
         end
         default: ;
      endcase

      if (act_oc) begin
         beep = BEEP_SHORT;
         if (lock_ff) begin
            status = ST_LOCKED_ERR;
         end else begin
            relay_in = drive;
            status   = (drive == RELAY_OPEN) ? ST_OPEN : ST_CLOSE;
            if (tlearn_ff) begin
               if (!measuring_ff) begin
                  timeout_rem_in = '0;
                  measuring_in   = 1'b1;
                  measured_in    = '0;
               end
            end else begin
               travel_rem_in = period(travel_ff);
            end
         end
      end

      if (act_stop) begin
         beep = BEEP_SHORT;
         if (learn_step_ff != STEP_IDLE) begin
            learn_step_in  = STEP_IDLE;
            timeout_rem_in = '0;
            status         = ST_RF_CANCEL;
         end else begin
            relay_in       = RELAY_OFF;
            travel_rem_in  = '0;
            timeout_rem_in = '0;
            if (tlearn_ff) begin
               if (measuring_ff) begin
                  if (32'(measured_ff) > 32'(cfg.min_learn_ms)) begin
                     travel_in   = measured_ff;
                     learned_in  = 1'b1;
                     save_travel = 1'b1;
                     beep        = BEEP_LONG;
                     status      = ST_CAL_DONE;
                  end else begin
                     status = ST_CAL_SHORT;
                  end
               end else begin
                  status = ST_CAL_CANCEL;
               end
               tlearn_in    = 1'b0;
               measuring_in = 1'b0;
               measured_in  = '0;
            end else begin
               status = ST_STOP;
            end
         end
      end

      if (act_lock) begin
         lock_in = lock_val;
         beep    = BEEP_SHORT;
         if (lock_val) begin
            relay_in = RELAY_OFF;
            status   = ST_LOCKED;
         end else begin
            status = ST_UNLOCKED;
         end
      end
   end

   always_comb begin
      result.relay_drive       = relay_in;
      result.status            = status;
      result.beep              = beep;
      result.timeout_mask      = mask;
      result.wifi_config_start = wifi_start;
      result.save_codes        = save_codes;
      result.save_travel       = save_travel;
      result.travel_time_ms    = travel_wide[REG_BITS-1:0];
      result.locked            = lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_ff        <= 1'b0;
         relay_ff       <= RELAY_OFF;
         travel_ff      <= to_time(DEFAULT_TRAVEL_RESET);
         travel_rem_ff  <= '0;
         timeout_rem_ff <= '0;
         tlearn_ff      <= 1'b0;
         measuring_ff   <= 1'b0;
         measured_ff    <= '0;
         wifi_ff        <= 1'b0;
         learn_step_ff  <= STEP_IDLE;
         learned_ff     <= 1'b0;
         saved_ff       <= '{default: '0};
      end else if (step) begin
         lock_ff        <= lock_in;
         relay_ff       <= relay_in;
         travel_ff      <= travel_in;
         travel_rem_ff  <= travel_rem_in;
         timeout_rem_ff <= timeout_rem_in;
         tlearn_ff      <= tlearn_in;
         measuring_ff   <= measuring_in;
         measured_ff    <= measured_in;
         wifi_ff        <= wifi_in;
         learn_step_ff  <= learn_step_in;
         learned_ff     <= learned_in;
         saved_ff       <= saved_in;
      end else if (default_we && !learned_ff) begin
         travel_ff <= to_time(default_value);
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         pending_ff <= pending_in;
      end
   end

endmodule

// ----- sv/door_motor_learning_controller_unit.sv -----
// Top level of the door motor learning controller with stream and register ports.
//
// Each req transaction carries one operation (tick, RF code, door command, lock,
// learning start or wifi mode) and produces exactly one rsp transaction with the
// relay drive, status, beep request, timeout mask, one-shot save flags, current
// travel time and lock flag. The operation is captured in an input register; the
// state update and result go from it into the result register when it is free,
// so rsp_tvalid rises once the transaction has passed both. One transaction per
// cycle is sustained while the receiver does not stall; the update of the
// controller state is the only loop in the path. When the receiver stalls, the
// result register holds and the input register absorbs one more transaction
// before req_tready drops. Reset clears the state, empties both registers and
// loads the csr registers with their defaults. The user must write the csr
// registers only while no transaction is in flight, which the block does not
// check; a default_travel_ms write also sets the travel time until one is learned.
module door_motor_learning_controller_unit #(
   parameter int CODE_BITS = 24,
   parameter int TIME_BITS = 20
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // rf_code[23:0]
   input  logic [3:0]  req_tuser,   // operation[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // relay_drive, status, beep, timeout_mask,
                                    // wifi_config_start, save_codes, save_travel,
                                    // travel_time_ms, locked
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import dmlc_pkg::*;

   logic                 s1_valid_ff;
   logic [3:0]           s1_op_ff;
   logic [CODE_BITS-1:0] s1_code_ff;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;
   result_type           result;
   cfg_type              cfg_ff;
   logic                 advance;
   logic                 cfg_we;
   logic [1:0]           reg_idx;
   logic [31:0]          code_wide;

   assign code_wide  = 32'(req_tdata);
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 40'(rsp_data_ff);
   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[3:2];
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (reg_idx)
         REG_DEFAULT_TRAVEL: csr_prdata = 32'(cfg_ff.default_travel_ms);
         REG_MIN_LEARN:      csr_prdata = 32'(cfg_ff.min_learn_ms);
         REG_LEARN_TIMEOUT:  csr_prdata = 32'(cfg_ff.learn_timeout_ms);
         REG_RF_TIMEOUT:     csr_prdata = 32'(cfg_ff.rf_key_timeout_ms);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_travel_ms <= DEFAULT_TRAVEL_RESET;
         cfg_ff.min_learn_ms      <= MIN_LEARN_RESET;
         cfg_ff.learn_timeout_ms  <= LEARN_TIMEOUT_RESET;
         cfg_ff.rf_key_timeout_ms <= RF_TIMEOUT_RESET;
      end else if (cfg_we) begin
         unique case (reg_idx)
            REG_DEFAULT_TRAVEL: cfg_ff.default_travel_ms <= csr_pwdata[REG_BITS-1:0];
            REG_MIN_LEARN:      cfg_ff.min_learn_ms      <= csr_pwdata[REG_BITS-1:0];
            REG_LEARN_TIMEOUT:  cfg_ff.learn_timeout_ms  <= csr_pwdata[REG_BITS-1:0];
            REG_RF_TIMEOUT:     cfg_ff.rf_key_timeout_ms <= csr_pwdata[REG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            s1_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_op_ff   <= req_tuser;
         s1_code_ff <= code_wide[CODE_BITS-1:0];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   dmlc_engine #(
      .CODE_BITS (CODE_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .op            (s1_op_ff),
      .code          (s1_code_ff),
      .cfg           (cfg_ff),
      .default_we    (cfg_we && reg_idx == REG_DEFAULT_TRAVEL),
      .default_value (csr_pwdata[REG_BITS-1:0]),
      .result        (result)
   );

endmodule

// ----- tb/sv/tb_door_motor_learning_controller_unit.sv -----
// Self-checking testbench for the door motor learning controller with a scoreboard class.
`timescale 1ns / 100ps

module tb_door_motor_learning_controller_unit;
   import dmlc_pkg::*;

   localparam int          HALF_PERIOD   = 6;
   localparam int          RESET_CYCLES  = 9;
   localparam int          HOLD_CYCLES   = 64;
   localparam int          QUIET_LIMIT   = 4000;
   localparam logic [3:0]  OP_UNUSED_TOP = 4'd15;

   class door_controller_model;
      localparam int         MASK_WIFI   = 0;
      localparam int         MASK_RF     = 1;
      localparam int         MASK_TRAVEL = 2;
      localparam logic [2:0] STEP_IDLE   = 3'd0;
      localparam logic [2:0] STEP_FIRST  = 3'd1;
      localparam logic [2:0] STEP_LOCK   = 3'd4;

      logic [REG_BITS-1:0] dflt_travel, min_learn, learn_timeout, rf_timeout;
      bit                  door_locked, calibrating, timing, wifi_active, travel_learned;
      logic [1:0]          relay;
      logic [2:0]          rf_step;
      logic [REG_BITS-1:0] travel_ms, travel_left, guard_left, elapsed_ms;
      logic [23:0]         codes[4];
      logic [23:0]         staged[3];
      result_type          outcome;
      result_type          expected_q[$];
      int unsigned         mismatches, checked, noted;

      function new();
         dflt_travel    = DEFAULT_TRAVEL_RESET;
         min_learn      = MIN_LEARN_RESET;
         learn_timeout  = LEARN_TIMEOUT_RESET;
         rf_timeout     = RF_TIMEOUT_RESET;
         travel_ms      = DEFAULT_TRAVEL_RESET;
         door_locked    = 0;
         calibrating    = 0;
         timing         = 0;
         wifi_active    = 0;
         travel_learned = 0;
         relay          = RELAY_OFF;
         rf_step        = STEP_IDLE;
         travel_left    = '0;
         guard_left     = '0;
         elapsed_ms     = '0;
         foreach (codes[i]) codes[i] = '0;
         foreach (staged[i]) staged[i] = '0;
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("MISMATCH: %s", msg);
      endfunction

      function void write_reg(logic [1:0] idx, logic [REG_BITS-1:0] value);
         case (idx)
            REG_DEFAULT_TRAVEL: begin
               dflt_travel = value;
               if (!travel_learned) travel_ms = value;
            end
            REG_MIN_LEARN:     min_learn = value;
            REG_LEARN_TIMEOUT: learn_timeout = value;
            default:           rf_timeout = value;
         endcase
      endfunction

      function logic [REG_BITS-1:0] period(logic [REG_BITS-1:0] v);
         return (v == '0) ? REG_BITS'(1) : v;
      endfunction

      function void drive_door(logic [1:0] dir);
         outcome.beep = BEEP_SHORT;
         if (door_locked) begin
            outcome.status = ST_LOCKED_ERR;
            return;
         end
         relay = dir;
         outcome.status = (dir == RELAY_OPEN) ? ST_OPEN : ST_CLOSE;
         if (calibrating) begin
            if (!timing) begin
               guard_left = '0;
               timing     = 1;
               elapsed_ms = '0;
            end
         end else begin
            travel_left = period(travel_ms);
         end
      endfunction

      function void halt_door();
         outcome.beep = BEEP_SHORT;
         if (rf_step != STEP_IDLE) begin
            rf_step        = STEP_IDLE;
            guard_left     = '0;
            outcome.status = ST_RF_CANCEL;
            return;
         end
         relay       = RELAY_OFF;
         travel_left = '0;
         guard_left  = '0;
         if (calibrating) begin
            if (!timing) begin
               outcome.status = ST_CAL_CANCEL;
            end else if (elapsed_ms > min_learn) begin
               travel_ms           = elapsed_ms;
               travel_learned      = 1;
               outcome.save_travel = 1'b1;
               outcome.beep        = BEEP_LONG;
               outcome.status      = ST_CAL_DONE;
            end else begin
               outcome.status = ST_CAL_SHORT;
            end
            calibrating = 0;
            timing      = 0;
            elapsed_ms  = '0;
         end else begin
            outcome.status = ST_STOP;
         end
      endfunction

      function void set_lock(bit on);
         door_locked = on;
         if (on) relay = RELAY_OFF;
         outcome.status = on ? ST_LOCKED : ST_UNLOCKED;
         outcome.beep   = BEEP_SHORT;
      endfunction

      function void note_request(logic [3:0] op, logic [23:0] code);
         outcome = '0;
         noted++;
         case (op)
            OP_TICK: begin
               if (timing && elapsed_ms != '1) elapsed_ms++;
               if (travel_left != '0) begin
                  travel_left--;
                  if (travel_left == '0) begin
                     relay          = RELAY_OFF;
                     outcome.status = ST_STOP;
                  end
               end
               if (guard_left != '0) begin
                  guard_left--;
                  if (guard_left == '0) begin
                     if (wifi_active) begin
                        outcome.timeout_mask[MASK_WIFI] = 1'b1;
                        wifi_active = 0;
                     end
                     if (rf_step != STEP_IDLE) begin
                        outcome.timeout_mask[MASK_RF] = 1'b1;
                        rf_step = STEP_IDLE;
                     end
                     if (calibrating) begin
                        outcome.timeout_mask[MASK_TRAVEL] = 1'b1;
                        calibrating = 0;
                        timing      = 0;
                        elapsed_ms  = '0;
                     end
                     relay          = RELAY_OFF;
                     outcome.beep   = BEEP_SHORT;
                     outcome.status = ST_TIMEOUT;
                  end
               end
            end
            OP_RF: begin
               if (rf_step != STEP_IDLE) begin
                  outcome.beep = BEEP_SHORT;
                  if (rf_step != STEP_LOCK) begin
                     staged[rf_step - STEP_FIRST] = code;
                     rf_step++;
                     outcome.status = ST_RF_WAIT_OPEN + 5'(rf_step - STEP_FIRST);
                     guard_left     = period(rf_timeout);
                  end else begin
                     codes[0]           = staged[0];
                     codes[1]           = staged[1];
                     codes[2]           = staged[2];
                     codes[3]           = code;
                     outcome.save_codes = 1'b1;
                     rf_step            = STEP_IDLE;
                     guard_left         = '0;
                     outcome.status     = ST_RF_DONE;
                     outcome.beep       = BEEP_LONG;
                  end
               end else if (code == codes[0]) begin
                  drive_door(RELAY_OPEN);
               end else if (code == codes[1]) begin
                  halt_door();
               end else if (code == codes[2]) begin
                  drive_door(RELAY_CLOSE);
               end else if (code == codes[3]) begin
                  set_lock(!door_locked);
               end
            end
            OP_OPEN:        drive_door(RELAY_OPEN);
            OP_CLOSE:       drive_door(RELAY_CLOSE);
            OP_STOP:        halt_door();
            OP_LOCK:        set_lock(1);
            OP_UNLOCK:      set_lock(0);
            OP_LOCK_TOGGLE: set_lock(!door_locked);
            OP_LEARN_TRAVEL: begin
               outcome.beep = BEEP_SHORT;
               if (door_locked) begin
                  outcome.status = ST_LOCKED_ERR;
               end else begin
                  calibrating    = 1;
                  timing         = 0;
                  elapsed_ms     = '0;
                  relay          = RELAY_OFF;
                  guard_left     = period(learn_timeout);
                  outcome.status = ST_CAL_ON;
                  outcome.beep   = BEEP_LONG;
               end
            end
            OP_LEARN_RF: begin
               if (door_locked) begin
                  outcome.status = ST_LOCKED_ERR;
               end else begin
                  rf_step        = STEP_FIRST;
                  relay          = RELAY_OFF;
                  guard_left     = period(rf_timeout);
                  outcome.status = ST_RF_WAIT_OPEN;
                  outcome.beep   = BEEP_LONG;
               end
            end
            OP_WIFI: begin
               wifi_active               = 1;
               relay                     = RELAY_OFF;
               guard_left                = period(learn_timeout);
               outcome.wifi_config_start = 1'b1;
               outcome.beep              = BEEP_LONG;
            end
            default: ;
         endcase
         outcome.relay_drive    = relay;
         outcome.travel_time_ms = travel_ms;
         outcome.locked         = door_locked;
         expected_q.push_back(outcome);
      endfunction

      function string describe(result_type r);
         return $sformatf({"relay=%0d status=%0d beep=%0d mask=%0d wifi=%0d codes=%0d",
                           " travel=%0d ms=%0d lock=%0d"},
                          r.relay_drive, r.status, r.beep, r.timeout_mask, r.wifi_config_start,
                          r.save_codes, r.save_travel, r.travel_time_ms, r.locked);
      endfunction

      function void check_response(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            report({"result with nothing expected: ", describe(got)});
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (got.relay_drive !== want.relay_drive || got.status !== want.status ||
             got.beep !== want.beep || got.timeout_mask !== want.timeout_mask ||
             got.wifi_config_start !== want.wifi_config_start ||
             got.save_codes !== want.save_codes || got.save_travel !== want.save_travel ||
             got.travel_time_ms !== want.travel_time_ms || got.locked !== want.locked) begin
            report($sformatf("result %0d expected %s", checked, describe(want)));
            if (mismatches <= 10) $display("          actual   %s", describe(got));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [3:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   door_controller_model door = new();
   bit          send_idle = 1'b0;
   bit          recv_stall = 1'b0;
   bit          hold_off = 1'b0;
   int unsigned sent_count = 0;
   int unsigned quiet_cycles = 0;

   door_motor_learning_controller_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   function automatic int unsigned stall_len();
      return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 30);
   endfunction

   function automatic logic [23:0] pick_code();
      if ($urandom_range(0, 9) < 7) return door.codes[$urandom_range(0, 3)];
      return 24'($urandom);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) door.check_response(result_type'(rsp_tdata[35:0]));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off = 1'b0;
         end else if (recv_stall && $urandom_range(0, 2) == 0) begin
            rsp_tready = 1'b0;
            repeat (stall_len()) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   task automatic send_item(logic [3:0] op, logic [23:0] code);
      req_tdata  = code;
      req_tuser  = op;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      door.note_request(op, code);
      if (op <= OP_WIFI) sent_count++;
      @(negedge clock);
      if (send_idle && $urandom_range(0, 1) == 0) begin
         req_tvalid = 1'b0;
         repeat (stall_len()) @(negedge clock);
      end
   endtask

   task automatic send_ticks(int unsigned n);
      repeat (n) send_item(OP_TICK, 24'($urandom));
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (door.expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [REG_BITS-1:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = {12'b0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      door.write_reg(idx, value);
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      if (csr_prdata !== {12'b0, value})
         door.report($sformatf("register %0d read back %h, wrote %h", idx, csr_prdata, value));
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic configure(logic [REG_BITS-1:0] dflt, logic [REG_BITS-1:0] minl,
                            logic [REG_BITS-1:0] lto, logic [REG_BITS-1:0] rfto);
      drain();
      write_reg(REG_DEFAULT_TRAVEL, dflt);
      write_reg(REG_MIN_LEARN, minl);
      write_reg(REG_LEARN_TIMEOUT, lto);
      write_reg(REG_RF_TIMEOUT, rfto);
   endtask

   task automatic run_episode(int unsigned span);
      int unsigned kind, i, r;
      kind       = $urandom_range(0, 99);
      send_idle  = $urandom_range(0, 5) != 0;
      recv_stall = $urandom_range(0, 5) != 0;
      if (kind < 22) begin
         if ($urandom_range(0, 4) != 0) send_item(OP_UNLOCK, 24'($urandom));
         send_item(OP_LEARN_RF, 24'($urandom));
         for (i = 0; i < 4; i++) begin
            send_ticks($urandom_range(0, span));
            if ($urandom_range(0, 19) == 0) begin
               send_item(OP_STOP, 24'($urandom));
               break;
            end
            send_item(OP_RF, 24'($urandom));
         end
      end else if (kind < 42) begin
         if ($urandom_range(0, 4) != 0) send_item(OP_UNLOCK, 24'($urandom));
         send_item(OP_LEARN_TRAVEL, 24'($urandom));
         send_ticks($urandom_range(0, span));
         if ($urandom_range(0, 9) == 0) begin
            send_item(OP_STOP, 24'($urandom));
         end else begin
            send_item($urandom_range(0, 1) ? OP_OPEN : OP_CLOSE, 24'($urandom));
            send_ticks($urandom_range(0, 2 * span));
            if ($urandom_range(0, 6) != 0) send_item(OP_STOP, 24'($urandom));
         end
      end else if (kind < 50) begin
         send_item(OP_WIFI, 24'($urandom));
         send_ticks($urandom_range(0, 3 * span));
         if ($urandom_range(0, 2) == 0) send_item(OP_STOP, 24'($urandom));
      end else if (kind < 60) begin
         send_item(OP_LOCK + 4'($urandom_range(0, 2)), 24'($urandom));
         if ($urandom_range(0, 1)) send_item(OP_RF, pick_code());
         else send_item(OP_OPEN + 4'($urandom_range(0, 1)), 24'($urandom));
      end else begin
         repeat ($urandom_range(1, 8)) begin
            r = $urandom_range(0, 99);
            if (r < 40) send_item(OP_TICK, 24'($urandom));
            else if (r < 60) send_item(OP_RF, pick_code());
            else if (r < 85) send_item(OP_OPEN + 4'($urandom_range(0, 2)), 24'($urandom));
            else send_item(4'($urandom_range(0, 15)), 24'($urandom));
         end
      end
   endtask

   task automatic run_phase(int unsigned target, int unsigned span);
      int unsigned start, episode;
      start   = sent_count;
      episode = 0;
      while (sent_count - start < target) begin
         episode++;
         if (episode == 5) hold_off = 1'b1;
         if (episode == 12) drain();
         run_episode(span);
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      send_idle  = 1'b1;
      recv_stall = 1'b1;
      configure(20'd2, 20'd1, 20'd2, 20'd2);
      send_item(OP_RF, 24'h000000);
      send_item(OP_LOCK, 24'h000000);
      send_ticks(2);
      send_item(OP_LEARN_RF, 24'hFFFFFF);
      send_item(OP_UNLOCK, 24'h000000);
      send_item(OP_LEARN_TRAVEL, 24'h000000);
      send_item(OP_STOP, 24'h000000);
      send_item(OP_LEARN_TRAVEL, 24'h000000);
      send_item(OP_CLOSE, 24'h000000);
      send_ticks(1);
      send_item(OP_STOP, 24'h000000);
      send_item(OP_LEARN_TRAVEL, 24'h000000);
      send_item(OP_OPEN, 24'h000000);
      send_ticks(3);
      send_item(OP_STOP, 24'h000000);
      drain();
      write_reg(REG_DEFAULT_TRAVEL, 20'd5);
      send_item(OP_WIFI, 24'h000000);
      send_item(OP_LEARN_RF, 24'h000000);
      send_ticks(2);
      send_item(OP_LEARN_RF, 24'h000000);
      send_item(OP_RF, 24'hFFFFFF);
      send_item(OP_RF, 24'h000001);
      send_item(OP_RF, 24'hA5A5A5);
      send_item(OP_RF, 24'h5A5A5A);
      send_item(OP_RF, 24'h000001);
      send_item(OP_RF, 24'h123456);
      send_item(OP_UNUSED_TOP, 24'hFFFFFF);
      send_item(OP_LEARN_RF, 24'h000000);
      send_item(OP_STOP, 24'h000000);

      configure(20'd5, 20'd3, 20'd20, 20'd10);
      run_phase(600, 12);
      configure(20'd1, 20'd0, 20'd1, 20'd1);
      run_phase(500, 2);
      configure(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
      run_phase(400, 6);
      configure(20'd9, 20'd6, 20'd30, 20'd14);
      run_phase(500, 12);

      req_tvalid = 1'b0;
      while (door.expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (door.expected_q.size() != 0)
         door.report($sformatf("%0d results never arrived", door.expected_q.size()));
      $display("Covered %0d transactions and %0d checked results across several register sets,",
               door.noted, door.checked);
      $display("with travel and RF learning, timeouts, lock, wifi mode and receiver stalls.");
      if (door.mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches in total", door.mismatches);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/dmlc_pkg.sv
sv/dmlc_engine.sv
sv/door_motor_learning_controller_unit.sv
tb/sv/tb_door_motor_learning_controller_unit.sv
